/* hw/rtl/cbl_pkg.sv */
// Shared constants for the counter bank with lazy raise-all.
// No dependencies; compiled first.
`default_nettype none

package cbl_pkg;

    localparam int KIND_W  = 2;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 11;

    localparam int CNT_DEPTH_DEF = 1024;
    localparam int CNT_WIDTH_DEF = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic [KIND_W-1:0] KIND_INC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RAISE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

endpackage

`default_nettype wire

/* hw/rtl/cbl_if.sv */
// Valid/ready channel interfaces for command items and result items.
// Depends on cbl_pkg for field widths.
`default_nettype none

interface cbl_in_if;
    logic                         valid;
    logic                         ready;
    logic [cbl_pkg::KIND_W-1:0]   kind;
    logic [cbl_pkg::INDEX_W-1:0]  index;

    modport source (output valid, output kind, output index, input ready);
    modport sink   (input valid, input kind, input index, output ready);
endinterface

interface cbl_out_if;
    logic                         valid;
    logic                         ready;
    logic [cbl_pkg::VALUE_W-1:0]  value;
    logic                         out_of_range;

    modport source (output valid, output value, output out_of_range, input ready);
    modport sink   (input valid, input value, input out_of_range, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cbl_ram.sv */
// Simple dual-port counter memory: one write port, one read port, registered read.
// Depends on nothing beyond its parameters.
`default_nettype none

module cbl_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/counter_bank_with_lazy_raise_all.sv */
// Counter bank top level: command decode, read-modify-write stage, result register.
// Depends on cbl_pkg, cbl_if (cbl_in_if, cbl_out_if) and cbl_ram.
//
// Takes one item per cycle while results are taken: increment, raise-all or
// read. Counters live in a one-port-write, one-port-read memory with a
// registered read; an item is read at acceptance, modified and written back
// in the second stage, and its result then sits in an output register.
// Back-to-back hits on the same counter are forwarded, so the rate stays at
// one item per cycle while results are taken. Raise-all only copies the
// running maximum into a floor register; every read or increment lifts a
// counter to the floor. After reset the memory is zeroed by a clearing pass
// over every address, during which ready stays low; the register port works
// throughout. An increment or read index not below min(counters_in_use,
// COUNTER_DEPTH) returns value 0 with out_of_range set and changes nothing.
`default_nettype none

module counter_bank_with_lazy_raise_all import cbl_pkg::*; #(
    parameter int COUNTER_DEPTH = CNT_DEPTH_DEF,
    parameter int COUNT_WIDTH   = CNT_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    cbl_in_if.sink                req,
    cbl_out_if.source             rsp,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    localparam int ADDR_W  = (COUNTER_DEPTH > 1) ? $clog2(COUNTER_DEPTH) : 1;
    localparam int DLIM_W  = $clog2(COUNTER_DEPTH + 1);
    localparam int LIM_W   = (DLIM_W > CFG_W) ? DLIM_W : CFG_W;
    localparam logic [LIM_W-1:0]       DEPTH_L  = LIM_W'(COUNTER_DEPTH);
    localparam logic [ADDR_W-1:0]      LAST_A   = ADDR_W'(COUNTER_DEPTH - 1);
    localparam logic [COUNT_WIDTH-1:0] TOP      = '1;

    logic [CFG_W-1:0]       cfg_reg;
    logic                   clr_reg;
    logic [ADDR_W-1:0]      clr_addr_reg;

    logic                   s2_valid_reg;
    logic [KIND_W-1:0]      s2_kind_reg;
    logic                   s2_in_range_reg;
    logic [ADDR_W-1:0]      s2_addr_reg;
    logic                   s2_fwd_reg;
    logic [COUNT_WIDTH-1:0] s2_fwd_data_reg;

    logic [COUNT_WIDTH-1:0] max_reg;
    logic [COUNT_WIDTH-1:0] floor_reg;

    logic                   out_valid_reg;
    logic [VALUE_W-1:0]     out_value_reg;
    logic                   out_oor_reg;

    logic                   accept;
    logic                   s2_fire;
    logic [LIM_W-1:0]       idx_ext;
    logic                   in_range;
    logic [ADDR_W-1:0]      req_addr;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic [COUNT_WIDTH-1:0] base;
    logic [COUNT_WIDTH-1:0] lifted;
    logic [COUNT_WIDTH-1:0] bumped;
    logic [COUNT_WIDTH-1:0] res_count;
    logic                   res_oor;
    logic                   inc_wr;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;

    assign s2_fire   = s2_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !clr_reg && (!s2_valid_reg || s2_fire);
    assign accept    = req.valid && req.ready;

    assign idx_ext  = LIM_W'(req.index);
    assign in_range = (idx_ext < LIM_W'(cfg_reg)) && (idx_ext < DEPTH_L);
    assign req_addr = ADDR_W'(req.index);

    assign base   = s2_fwd_reg ? s2_fwd_data_reg : rd_data;
    assign lifted = (base < floor_reg) ? floor_reg : base;
    assign bumped = (lifted == TOP) ? lifted : lifted + COUNT_WIDTH'(1);

    always_comb
    begin
        res_count = '0;
        res_oor   = 1'b0;
        inc_wr    = 1'b0;
        case (s2_kind_reg)
            KIND_INC:
            begin
                res_oor = !s2_in_range_reg;
                if (s2_in_range_reg)
                begin
                    res_count = bumped;
                    inc_wr    = 1'b1;
                end
            end
            KIND_READ:
            begin
                res_oor = !s2_in_range_reg;
                if (s2_in_range_reg)
                begin
                    res_count = lifted;
                end
            end
            KIND_RAISE:
            begin
                res_count = max_reg;
            end
            default:
            begin
                res_count = '0;
            end
        endcase
    end

    assign mem_we    = clr_reg || (s2_fire && inc_wr);
    assign mem_waddr = clr_reg ? clr_addr_reg : s2_addr_reg;
    assign mem_wdata = clr_reg ? '0 : bumped;

    cbl_ram #(
        .DEPTH  (COUNTER_DEPTH),
        .WIDTH  (COUNT_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (req_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= CFG_RESET;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_A)
                begin
                    clr_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_reg       <= '0;
            floor_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s2_fire && inc_wr && (bumped > max_reg))
            begin
                max_reg <= bumped;
            end
            if (s2_fire && (s2_kind_reg == KIND_RAISE))
            begin
                floor_reg <= max_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_kind_reg     <= req.kind;
            s2_in_range_reg <= in_range;
            s2_addr_reg     <= req_addr;
            s2_fwd_reg      <= s2_fire && inc_wr && (s2_addr_reg == req_addr);
            s2_fwd_data_reg <= bumped;
        end
        if (s2_fire)
        begin
            out_value_reg <= VALUE_W'(res_count);
            out_oor_reg   <= res_oor;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.value        = out_value_reg;
    assign rsp.out_of_range = out_oor_reg;

endmodule

`default_nettype wire

/* test/counter_bank_with_lazy_raise_all_tb.sv */
// Self-checking testbench for counter_bank_with_lazy_raise_all: directed and random
// increment, raise-all and read items under several counter limits, checked in order.
// Depends on cbl_pkg, cbl_if and the RTL top level.
`default_nettype none

module counter_bank_with_lazy_raise_all_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbl_pkg::*;

    localparam int KIND_UNUSED = 3;

    class counter_scoreboard;
        typedef struct packed
        {
            logic [VALUE_W-1:0] value;
            logic               out_of_range;
        } counter_result_t;

        logic [VALUE_W-1:0] counts [CNT_DEPTH_DEF];
        logic [VALUE_W-1:0] peak;
        logic [VALUE_W-1:0] floor_level;
        logic [CFG_W-1:0]   in_use;
        counter_result_t    expected_q [$];
        int errors;
        int checked;
        int accepted;
        int raises;
        int rejected;

        function new();
            foreach (counts[i])
                counts[i] = '0;
            peak        = '0;
            floor_level = '0;
            in_use      = CFG_RESET;
            errors      = 0;
            checked     = 0;
            accepted    = 0;
            raises      = 0;
            rejected    = 0;
        endfunction

        function void set_limit(logic [CFG_W-1:0] v);
            in_use = v;
        endfunction

        function int active_limit();
            return (in_use > CNT_DEPTH_DEF) ? CNT_DEPTH_DEF : int'(in_use);
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // Lazy floor: a counter below the floor reads as the floor.
        function void note_input(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx);
            counter_result_t r;
            logic [VALUE_W-1:0] c;
            r = '0;
            accepted++;
            if (kind == KIND_INC || kind == KIND_READ)
            begin
                if (int'(idx) >= active_limit())
                begin
                    r.out_of_range = 1'b1;
                    rejected++;
                end
                else
                begin
                    c = (counts[idx] < floor_level) ? floor_level : counts[idx];
                    if (kind == KIND_INC)
                    begin
                        if (c != '1)
                            c = c + 1'b1;
                        counts[idx] = c;
                        if (c > peak)
                            peak = c;
                    end
                    r.value = c;
                end
            end
            else if (kind == KIND_RAISE)
            begin
                floor_level = peak;
                r.value     = floor_level;
                raises++;
            end
            expected_q.push_back(r);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("[%0t] MISMATCH %0d: %s", $realtime, errors, what);
        endtask

        task check_result(logic [VALUE_W-1:0] value, logic out_of_range);
            counter_result_t e;
            checked++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with nothing pending: value %0d oor %0b",
                                 value, out_of_range));
                return;
            end
            e = expected_q.pop_front();
            if (value !== e.value)
                report($sformatf("value %0d, expected %0d", value, e.value));
            if (out_of_range !== e.out_of_range)
                report($sformatf("out_of_range %0b, expected %0b",
                                 out_of_range, e.out_of_range));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    bit   idle_on;
    int   limits_used;
    int   stall_left;
    int   hot [4];

    counter_scoreboard sb = new();

    cbl_in_if  req ();
    cbl_out_if rsp ();

    counter_bank_with_lazy_raise_all dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Result side: check on handshake, then decide ready for the next edge.
    initial
    begin
        rsp.ready <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
                sb.check_result(rsp.value, rsp.out_of_range);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] k, input logic [INDEX_W-1:0] ix);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.kind  <= k;
        req.index <= ix;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        sb.note_input(k, ix);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        req.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_limit(v);
        limits_used++;
    endtask

    // Mix: hot counters (forwarding, high counts), in-range spread, full index range.
    task automatic run_random(input int n);
        int lim;
        int sel;
        logic [KIND_W-1:0]  k;
        logic [INDEX_W-1:0] ix;
        lim = sb.active_limit();
        foreach (hot[i])
            hot[i] = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 1023);
        for (int i = 0; i < n; i++)
        begin
            if (i % 25 == 0 && i > 0 && limits_used < 100)
                idle_on = ($urandom_range(0, 2) != 0);
            sel = $urandom_range(0, 99);
            if (sel < 45 || lim == 0)
                ix = (lim == 0 && sel >= 45) ? INDEX_W'($urandom_range(0, 1023))
                                             : INDEX_W'(hot[$urandom_range(0, 3)]);
            else if (sel < 85)
                ix = INDEX_W'($urandom_range(0, lim - 1));
            else
                ix = INDEX_W'($urandom_range(0, 1023));
            sel = $urandom_range(0, 99);
            if (sel < 62)
                k = KIND_INC;
            else if (sel < 82)
                k = KIND_READ;
            else if (sel < 94)
                k = KIND_RAISE;
            else if (sel < 97)
                k = KIND_W'(KIND_UNUSED);
            else
                k = KIND_INC;
            send_item(k, ix);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] limits [8];
        req.valid  <= 1'b0;
        req.kind   <= KIND_INC;
        req.index  <= '0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        idle_on     = 1'b1;
        limits_used = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: cleared store, floor lifting, back-to-back hits, unused kind.
        send_item(KIND_READ, 10'd0);
        send_item(KIND_INC, 10'd0);
        send_item(KIND_INC, 10'd0);
        send_item(KIND_INC, 10'd1023);
        send_item(KIND_READ, 10'd1023);
        send_item(KIND_RAISE, 10'd0);
        send_item(KIND_READ, 10'd5);
        send_item(KIND_INC, 10'd5);
        send_item(KIND_W'(KIND_UNUSED), 10'd1023);
        send_item(KIND_RAISE, 10'd1023);
        send_item(KIND_INC, 10'd1023);
        send_item(KIND_INC, 10'd1023);
        send_item(KIND_INC, 10'd1023);
        send_item(KIND_READ, 10'd1023);
        send_item(KIND_READ, 10'd682);
        write_limit(11'd1);
        send_item(KIND_INC, 10'd0);
        send_item(KIND_INC, 10'd1);
        send_item(KIND_READ, 10'd1023);
        write_limit(11'd0);
        send_item(KIND_INC, 10'd0);
        send_item(KIND_READ, 10'd0);
        send_item(KIND_RAISE, 10'd341);
        write_limit(11'd2047);
        send_item(KIND_INC, 10'd1023);
        send_item(KIND_READ, 10'd512);

        limits[0] = 11'd1024;
        limits[1] = 11'd16;
        limits[2] = 11'd2047;
        limits[3] = CFG_W'($urandom_range(2, 1023));
        limits[4] = 11'd1;
        limits[5] = 11'd0;
        limits[6] = CFG_W'($urandom_range(1025, 2046));
        limits[7] = 11'd1024;
        foreach (limits[p])
        begin
            write_limit(limits[p]);
            if (p == 7)
            begin
                idle_on = 1'b0;
                limits_used = limits_used + 100;
            end
            run_random(72);
        end
        limits_used = limits_used - 100;

        req.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d results never arrived", sb.outstanding()));

        $display("Covered %0d items (%0d raise-all, %0d out of range) over %0d limit writes;",
                 sb.accepted, sb.raises, sb.rejected, limits_used);
        $display("%0d results checked, highest count reached %0d.", sb.checked, sb.peak);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire

/* counter_bank_with_lazy_raise_all.f */
hw/rtl/cbl_pkg.sv
hw/rtl/cbl_if.sv
hw/rtl/cbl_ram.sv
hw/rtl/counter_bank_with_lazy_raise_all.sv
test/counter_bank_with_lazy_raise_all_tb.sv
